@@ hdl/bmpc_pkg.sv @@
// Shared types, constants and address helpers for the bubble memory page controller.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmpc_pkg;

   // byte store size and address widths
   localparam int STORE_BYTES = 131072;
   localparam int STORE_AW    = $clog2(STORE_BYTES);
   localparam int MEDIA_AW    = 17;
   localparam int SMALL_BYTES = 'h8000;
   localparam int LARGE_BYTES = 'h20000;

   // smallest address that is out of range for each media size
   localparam logic [MEDIA_AW:0] LIMIT_SMALL =
      (MEDIA_AW+1)'((SMALL_BYTES < STORE_BYTES) ? SMALL_BYTES : STORE_BYTES);
   localparam logic [MEDIA_AW:0] LIMIT_LARGE =
      (MEDIA_AW+1)'((LARGE_BYTES < STORE_BYTES) ? LARGE_BYTES : STORE_BYTES);
   localparam logic [MEDIA_AW:0] STORE_END = (MEDIA_AW+1)'(STORE_BYTES);

   // page geometry
   localparam logic [15:0] PAGE_MASK_SMALL = 16'h03ff;
   localparam logic [15:0] PAGE_MASK_LARGE = 16'h07ff;
   localparam logic [6:0]  PAGE_SIZE_SMALL = 7'h20;
   localparam logic [6:0]  PAGE_SIZE_LARGE = 7'h40;

   // status flag bit positions
   localparam int ST_BUSY = 0;
   localparam int ST_ERR  = 1;
   localparam int ST_RDA  = 2;
   localparam int ST_TDRA = 3;
   localparam int ST_CERR = 4;

   // error flag bit positions
   localparam int ER_UNDEF = 0;
   localparam int ER_NOMRK = 1;
   localparam int ER_POVR  = 5;
   localparam int ER_EJECT = 6;

   // bus operations
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // bus register indexes
   localparam logic [2:0] REG_DATA     = 3'd0;
   localparam logic [2:0] REG_CMD      = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_ERROR    = 3'd3;
   localparam logic [2:0] REG_PAGE_HI  = 3'd4;
   localparam logic [2:0] REG_PAGE_LO  = 3'd5;
   localparam logic [2:0] REG_COUNT_HI = 3'd6;
   localparam logic [2:0] REG_COUNT_LO = 3'd7;

   // command codes
   localparam logic [7:0] CMD_READ      = 8'd1;
   localparam logic [7:0] CMD_WRITE     = 8'd2;
   localparam logic [7:0] CMD_RESET     = 8'd4;
   localparam logic [7:0] CMD_RESET_ALT = 8'd15;

   // configuration register indexes
   localparam logic [1:0] CSR_MEDIA_LARGE   = 2'd0;
   localparam logic [1:0] CSR_MEDIA_PRESENT = 2'd1;
   localparam logic [1:0] CSR_PROTECT_ON    = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [2:0] reg_index;
      logic [7:0] write_byte;
   } bus_req_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          wdata;
   } store_req_type;

   // byte address of an offset within a page, page number masked to media size
   function automatic logic [MEDIA_AW-1:0] page_addr(input logic [15:0] page,
                                                     input logic large_media,
                                                     input logic [5:0] off);
      logic [MEDIA_AW-1:0] a;
      if (large_media) begin
         a = {page[10:0], off};
      end else begin
         a = {2'b00, page[9:0], off[4:0]};
      end
      return a;
   endfunction

endpackage

`default_nettype wire

@@ hdl/bmpc_store.sv @@
// Byte store of the page controller: single-port synchronous RAM, registered read.
// Runs a clearing pass over every byte after reset. Depends on bmpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpc_store
   import bmpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_req_type store_req,
   output logic [7:0]         rdata,
   output logic               clear_busy
);

   localparam logic [STORE_AW-1:0] LAST_ADDR = STORE_AW'(STORE_BYTES - 1);

   logic [7:0]          mem [STORE_BYTES];
   logic [7:0]          rdata_ff;
   logic                clr_busy_ff;
   logic                clr_busy_in;
   logic [STORE_AW-1:0] clr_addr_ff;
   logic [STORE_AW-1:0] clr_addr_in;

   // clearing sweep, one byte a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // memory write port, shared between the sweep and requests
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (store_req.wr_en) begin
         mem[store_req.addr] <= store_req.wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rdata_ff <= mem[store_req.addr];
      end
   end

   assign rdata      = rdata_ff;
   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

@@ hdl/bmpc_ctrl.sv @@
// Register file and request sequencing of the page controller.
// Reads and writes the byte store. Depends on bmpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpc_ctrl
   import bmpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write,
   input  wire logic [1:0]    csr_index,
   input  wire logic [0:0]    csr_data,
   input  wire logic          accept,
   input  wire bus_req_type   req,
   input  wire logic [7:0]    store_rdata,
   output store_req_type      store_req,
   output logic [7:0]         result
);

   logic        large_ff, large_in;
   logic        present_ff, present_in;
   logic        protect_ff, protect_in;
   logic [7:0]  latch_ff, latch_in;
   logic        pend_ff, pend_in;
   logic        zero_ff, zero_in;
   logic [7:0]  last_ff, last_in;
   logic [15:0] page_ff, page_in;
   logic [15:0] count_ff, count_in;
   logic [6:0]  off_ff, off_in;
   logic [4:0]  st_ff, st_in;
   logic [6:0]  er_ff, er_in;

   logic [7:0]          lat;
   logic [15:0]         page_mask;
   logic [6:0]          page_len;
   logic [MEDIA_AW:0]   limit;
   logic [5:0]          off_m;
   logic [6:0]          off_inc;
   logic                last_byte;
   logic [MEDIA_AW-1:0] addr_cur;
   logic [MEDIA_AW-1:0] addr_step;
   logic [MEDIA_AW-1:0] addr_base;
   logic [MEDIA_AW-1:0] addr_next;
   logic [15:0]         page_next;
   logic [15:0]         count_dec;
   logic                over;
   logic [4:0]          st_s;

   // configuration registers
   always_comb begin
      large_in   = large_ff;
      present_in = present_ff;
      protect_in = protect_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MEDIA_LARGE:   large_in   = csr_data[0];
            CSR_MEDIA_PRESENT: present_in = csr_data[0];
            CSR_PROTECT_ON:    protect_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // data latch as seen now: a store read issued last cycle lands here
   assign lat = pend_ff ? (zero_ff ? 8'h00 : store_rdata) : latch_ff;

   // page geometry and addresses
   assign page_mask = large_ff ? PAGE_MASK_LARGE : PAGE_MASK_SMALL;
   assign page_len  = large_ff ? PAGE_SIZE_LARGE : PAGE_SIZE_SMALL;
   assign limit     = large_ff ? LIMIT_LARGE : LIMIT_SMALL;
   assign off_m     = large_ff ? off_ff[5:0] : {1'b0, off_ff[4:0]};
   assign off_inc   = {1'b0, off_m} + 7'd1;
   assign last_byte = (off_inc == page_len);
   assign page_next = (page_ff + 16'd1) & page_mask;
   assign count_dec = (count_ff == 16'd0) ? 16'd0 : count_ff - 16'd1;
   assign addr_cur  = page_addr(page_ff, large_ff, off_m);
   assign addr_step = page_addr(page_ff, large_ff, off_inc[5:0]);
   assign addr_base = page_addr(page_ff, large_ff, 6'd0);
   assign addr_next = page_addr(page_next, large_ff, 6'd0);
   assign over      = ({1'b0, addr_cur} >= limit);

   // status register as seen by a status read, with ready bits re-armed
   always_comb begin
      st_s = st_ff;
      if (!present_ff) begin
         st_s[ST_BUSY] = 1'b0;
      end
      if (last_ff == CMD_READ && present_ff) begin
         st_s[ST_RDA] = 1'b1;
      end else if (last_ff == CMD_WRITE && present_ff) begin
         st_s[ST_TDRA] = 1'b1;
      end
   end

   // request processing
   always_comb begin
      latch_in  = lat;
      pend_in   = 1'b0;
      zero_in   = 1'b0;
      last_in   = last_ff;
      page_in   = page_ff;
      count_in  = count_ff;
      off_in    = off_ff;
      st_in     = st_ff;
      er_in     = er_ff;
      store_req = '0;
      result    = 8'h00;
      if (accept) begin
         if (req.operation == OP_READ) begin
            case (req.reg_index)
               REG_DATA: begin
                  result = lat;
                  if (st_ff[ST_RDA]) begin
                     if (over) begin
                        er_in[ER_POVR] = 1'b1;
                        st_in[ST_ERR]  = 1'b1;
                        st_in[ST_CERR] = 1'b1;
                     end else if (last_byte) begin
                        st_in[ST_BUSY] = 1'b0;
                        st_in[ST_RDA]  = 1'b0;
                        st_in[ST_CERR] = 1'b1;
                        off_in         = 7'd0;
                        count_in       = count_dec;
                        if (count_dec != 16'd0) begin
                           st_in[ST_BUSY]  = 1'b1;
                           st_in[ST_CERR]  = 1'b0;
                           page_in         = page_next;
                           store_req.rd_en = 1'b1;
                           store_req.addr  = addr_next[STORE_AW-1:0];
                           pend_in         = 1'b1;
                           zero_in         = ({1'b0, addr_next} >= STORE_END);
                        end
                     end else begin
                        off_in          = off_inc;
                        st_in[ST_CERR]  = 1'b0;
                        st_in[ST_BUSY]  = 1'b1;
                        store_req.rd_en = 1'b1;
                        store_req.addr  = addr_step[STORE_AW-1:0];
                        pend_in         = 1'b1;
                        zero_in         = ({1'b0, addr_step} >= STORE_END);
                     end
                  end
               end
               REG_STATUS: begin
                  st_in  = st_s;
                  result = {st_s[ST_CERR], st_s[ST_TDRA], st_s[ST_RDA], 3'b000,
                            st_s[ST_ERR], st_s[ST_BUSY]};
               end
               REG_ERROR: begin
                  result = {er_ff[ER_EJECT], 1'b0, er_ff[5:0]};
               end
               default: begin
                  result = 8'hff;
               end
            endcase
         end else begin
            case (req.reg_index)
               REG_DATA: begin
                  latch_in = req.write_byte;
                  if (st_ff[ST_TDRA]) begin
                     if (over) begin
                        er_in[ER_POVR] = 1'b1;
                        st_in[ST_ERR]  = 1'b1;
                        st_in[ST_CERR] = 1'b1;
                     end else begin
                        store_req.wr_en = 1'b1;
                        store_req.addr  = addr_cur[STORE_AW-1:0];
                        store_req.wdata = req.write_byte;
                        if (last_byte) begin
                           st_in[ST_BUSY] = 1'b0;
                           st_in[ST_TDRA] = 1'b0;
                           st_in[ST_CERR] = 1'b1;
                           st_in[ST_ERR]  = 1'b0;
                           off_in         = 7'd0;
                           count_in       = count_dec;
                           if (count_dec != 16'd0) begin
                              st_in[ST_BUSY] = 1'b1;
                              st_in[ST_CERR] = 1'b0;
                              page_in        = page_next;
                           end
                        end else begin
                           off_in = off_inc;
                        end
                     end
                  end
               end
               REG_CMD: begin
                  st_in   = '0;
                  er_in   = '0;
                  last_in = req.write_byte;
                  case (req.write_byte)
                     CMD_READ: begin
                        off_in = 7'd0;
                        if (!present_ff) begin
                           st_in[ST_ERR]   = 1'b1;
                           st_in[ST_CERR]  = 1'b1;
                           er_in[ER_NOMRK] = 1'b1;
                        end else begin
                           st_in[ST_RDA]   = 1'b1;
                           store_req.rd_en = 1'b1;
                           store_req.addr  = addr_base[STORE_AW-1:0];
                           pend_in         = 1'b1;
                           zero_in         = ({1'b0, addr_base} >= STORE_END);
                        end
                     end
                     CMD_WRITE: begin
                        st_in[ST_BUSY] = 1'b1;
                        if (!present_ff) begin
                           st_in[ST_ERR]   = 1'b1;
                           st_in[ST_CERR]  = 1'b1;
                           er_in[ER_NOMRK] = 1'b1;
                        end else if (protect_ff) begin
                           st_in[ST_BUSY] = 1'b0;
                           st_in[ST_CERR] = 1'b1;
                        end else begin
                           off_in         = 7'd0;
                           st_in[ST_TDRA] = 1'b1;
                        end
                     end
                     CMD_RESET, CMD_RESET_ALT: begin
                        latch_in = 8'h00;
                        page_in  = 16'd0;
                        count_in = 16'd0;
                     end
                     default: begin
                        st_in[ST_ERR]   = 1'b1;
                        st_in[ST_CERR]  = 1'b1;
                        er_in[ER_UNDEF] = 1'b1;
                     end
                  endcase
               end
               REG_PAGE_HI:  page_in  = {req.write_byte, page_ff[7:0]};
               REG_PAGE_LO:  page_in  = {page_ff[15:8], req.write_byte};
               REG_COUNT_HI: count_in = {req.write_byte, count_ff[7:0]};
               REG_COUNT_LO: count_in = {count_ff[15:8], req.write_byte};
               default: ;
            endcase
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         large_ff   <= 1'b0;
         present_ff <= 1'b0;
         protect_ff <= 1'b0;
         latch_ff   <= 8'h00;
         pend_ff    <= 1'b0;
         zero_ff    <= 1'b0;
         last_ff    <= 8'h00;
         page_ff    <= 16'd0;
         count_ff   <= 16'd0;
         off_ff     <= 7'd0;
         st_ff      <= '0;
         er_ff      <= '0;
      end else begin
         large_ff   <= large_in;
         present_ff <= present_in;
         protect_ff <= protect_in;
         latch_ff   <= latch_in;
         pend_ff    <= pend_in;
         zero_ff    <= zero_in;
         last_ff    <= last_in;
         page_ff    <= page_in;
         count_ff   <= count_in;
         off_ff     <= off_in;
         st_ff      <= st_in;
         er_ff      <= er_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/bmpc_resp_buf.sv @@
// Response output register with a skid stage for the page controller.
// Holds up to two read bytes while the consumer stalls. Depends on bmpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpc_resp_buf
   import bmpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] push_data,
   output logic            full,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [7:0] skid_data_ff, skid_data_in;

   // refill the output register from the skid stage first, then from a new request
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full          = skid_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_read_byte = out_data_ff;

endmodule

`default_nettype wire

@@ hdl/bubble_memory_page_controller.sv @@
// Read bytes are registered in the output register, or the skid stage while the
// consumer stalls. One request per cycle while req_stall is low; the single-port
// byte store is read or written at most once per request, and its read data is
// taken up by the following request. Reset: synchronous; then a clearing pass
// zeroes the store, one byte a cycle, with req_stall high and csr writes taken.
`timescale 1ns / 1ps
`default_nettype none

module bubble_memory_page_controller
   import bmpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [0:0] csr_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire logic [2:0] req_reg_index,
   input  wire logic [7:0] req_write_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte
);

   bus_req_type   req;
   store_req_type store_req;
   logic [7:0]    store_rdata;
   logic          clear_busy;
   logic          buf_full;
   logic          accept;
   logic [7:0]    result;

   // request handshake
   assign req_stall = buf_full || clear_busy;
   assign accept    = req_valid && !req_stall;
   assign req       = '{operation: req_operation, reg_index: req_reg_index,
                        write_byte: req_write_byte};

   bmpc_store u_store (
      .clock      (clock),
      .reset      (reset),
      .store_req  (store_req),
      .rdata      (store_rdata),
      .clear_busy (clear_busy)
   );

   bmpc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .accept      (accept),
      .req         (req),
      .store_rdata (store_rdata),
      .store_req   (store_req),
      .result      (result)
   );

   bmpc_resp_buf u_resp_buf (
      .clock         (clock),
      .reset         (reset),
      .push          (accept),
      .push_data     (result),
      .full          (buf_full),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule

`default_nettype wire

@@ test/bubble_memory_page_controller_tb.sv @@
// Self-checking testbench for the bubble memory page controller: byte bus requests with
// a live model of the page store, random idling on both channels and media settings.
// Depends on bmpc_pkg and the bubble_memory_page_controller RTL only.
`timescale 1ns / 1ps

module bubble_memory_page_controller_tb;
   import bmpc_pkg::*;

   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 20;

   typedef struct {
      bus_req_type req;
      int          gap;
   } pending_access_type;

   // clock, reset and block ports
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_write      = 1'b0;
   logic [1:0] csr_index      = CSR_MEDIA_LARGE;
   logic [0:0] csr_data       = 1'b0;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_operation  = OP_READ;
   logic [2:0] req_reg_index  = REG_DATA;
   logic [7:0] req_write_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_read_byte;

   // stimulus and scoreboard bookkeeping
   pending_access_type pending_accesses[$];
   logic [7:0]      expected_bytes[$];
   logic            req_took    = 1'b0;
   logic            rsp_took    = 1'b0;
   int              idle_cycles = 0;
   int              stall_left  = 0;
   int              hold_left   = 0;
   logic            hold_done   = 1'b0;
   logic            rsp_quiet   = 1'b0;
   logic            send_calm   = 1'b0;
   int              calm_left   = 0;
   int              rsp_count   = 0;
   int              fail_count  = 0;
   int              queued_total = 0;

   // mirror of the controller state
   logic       cfg_large, cfg_present, cfg_protect;
   logic [7:0] m_latch, m_last_cmd;
   logic [15:0] m_page, m_count;
   logic [6:0] m_offset;
   logic [4:0] m_status;
   logic [6:0] m_errors;
   logic [7:0] store_image [STORE_BYTES];

   always #5 clock = ~clock;

   bubble_memory_page_controller dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_reg_index  (req_reg_index),
      .req_write_byte (req_write_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte)
   );

   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   // page geometry for the current media size
   function automatic int unsigned page_bytes();
      return cfg_large ? PAGE_SIZE_LARGE : PAGE_SIZE_SMALL;
   endfunction

   function automatic logic [15:0] page_mask();
      return cfg_large ? PAGE_MASK_LARGE : PAGE_MASK_SMALL;
   endfunction

   function automatic int unsigned page_base();
      logic [15:0] masked;
      masked = m_page & page_mask();
      return masked * page_bytes();
   endfunction

   function automatic int unsigned addr_limit();
      int unsigned lim;
      lim = cfg_large ? LARGE_BYTES : SMALL_BYTES;
      if (lim > STORE_BYTES) lim = STORE_BYTES;
      return lim;
   endfunction

   function automatic logic [7:0] stored_byte(input int unsigned a);
      return (a < STORE_BYTES) ? store_image[a] : 8'h00;
   endfunction

   function automatic void flag_overrun();
      m_errors[ER_POVR] = 1'b1;
      m_status[ST_ERR]  = 1'b1;
      m_status[ST_CERR] = 1'b1;
   endfunction

   function automatic void advance_page();
      m_page = (m_page + 16'd1) & page_mask();
   endfunction

   // data register read: returns the latch, then fetches the next byte
   function automatic logic [7:0] read_data_reg();
      logic [7:0]  val;
      int unsigned ps, off, a;
      val = m_latch;
      ps  = page_bytes();
      off = m_offset;
      off = off & (ps - 1);
      a   = page_base() + off;
      if (!m_status[ST_RDA]) return val;
      if (a >= addr_limit()) begin
         flag_overrun();
         return val;
      end
      off++;
      if (off == ps) begin
         m_status[ST_BUSY] = 1'b0;
         m_status[ST_RDA]  = 1'b0;
         m_status[ST_CERR] = 1'b1;
         m_offset = '0;
         if (m_count != 0) m_count--;
         if (m_count != 0) begin
            m_status[ST_BUSY] = 1'b1;
            m_status[ST_CERR] = 1'b0;
            advance_page();
            m_latch = stored_byte(page_base());
         end
      end else begin
         m_offset = 7'(off);
         m_latch  = stored_byte(page_base() + off);
         m_status[ST_CERR] = 1'b0;
         m_status[ST_BUSY] = 1'b1;
      end
      return val;
   endfunction

   // data register write: stores the byte while a write transfer is open
   function automatic void write_data_reg(input logic [7:0] v);
      int unsigned ps, off, a;
      ps  = page_bytes();
      off = m_offset;
      off = off & (ps - 1);
      a   = page_base() + off;
      m_latch = v;
      if (!m_status[ST_TDRA]) return;
      if (a >= addr_limit()) begin
         flag_overrun();
         return;
      end
      store_image[a] = v;
      off++;
      if (off == ps) begin
         m_status[ST_BUSY] = 1'b0;
         m_status[ST_TDRA] = 1'b0;
         m_status[ST_CERR] = 1'b1;
         m_status[ST_ERR]  = 1'b0;
         m_offset = '0;
         if (m_count != 0) m_count--;
         if (m_count != 0) begin
            m_status[ST_BUSY] = 1'b1;
            m_status[ST_CERR] = 1'b0;
            advance_page();
         end
      end else begin
         m_offset = 7'(off);
      end
   endfunction

   function automatic void run_command(input logic [7:0] c);
      m_status   = '0;
      m_errors   = '0;
      m_last_cmd = c;
      case (c)
         CMD_READ: begin
            m_offset = '0;
            if (!cfg_present) begin
               m_status[ST_ERR]    = 1'b1;
               m_status[ST_CERR]   = 1'b1;
               m_errors[ER_NOMRK]  = 1'b1;
            end else begin
               m_latch = stored_byte(page_base());
               m_status[ST_RDA] = 1'b1;
            end
         end
         CMD_WRITE: begin
            m_status[ST_BUSY] = 1'b1;
            if (!cfg_present) begin
               m_status[ST_ERR]   = 1'b1;
               m_status[ST_CERR]  = 1'b1;
               m_errors[ER_NOMRK] = 1'b1;
            end else if (cfg_protect) begin
               m_status[ST_BUSY] = 1'b0;
               m_status[ST_CERR] = 1'b1;
            end else begin
               m_offset = '0;
               m_status[ST_TDRA] = 1'b1;
            end
         end
         CMD_RESET, CMD_RESET_ALT: begin
            m_latch = '0;
            m_page  = '0;
            m_count = '0;
         end
         default: begin
            m_status[ST_ERR]   = 1'b1;
            m_status[ST_CERR]  = 1'b1;
            m_errors[ER_UNDEF] = 1'b1;
         end
      endcase
   endfunction

   // status read re-arms the ready bit of the last transfer command
   function automatic logic [7:0] read_status_reg();
      if (!cfg_present) m_status[ST_BUSY] = 1'b0;
      if (m_last_cmd == CMD_READ && cfg_present) m_status[ST_RDA] = 1'b1;
      else if (m_last_cmd == CMD_WRITE && cfg_present) m_status[ST_TDRA] = 1'b1;
      return {m_status[ST_CERR], m_status[ST_TDRA], m_status[ST_RDA], 3'b000,
              m_status[ST_ERR], m_status[ST_BUSY]};
   endfunction

   // expected read byte of one bus request, updating the mirror
   function automatic logic [7:0] predict_access(input bus_req_type r);
      if (r.operation == OP_READ) begin
         case (r.reg_index)
            REG_DATA:   return read_data_reg();
            REG_STATUS: return read_status_reg();
            REG_ERROR:  return {m_errors[ER_EJECT], 1'b0, m_errors[5:0]};
            default:    return 8'hff;
         endcase
      end
      case (r.reg_index)
         REG_DATA:     write_data_reg(r.write_byte);
         REG_CMD:      run_command(r.write_byte);
         REG_PAGE_HI:  m_page[15:8]  = r.write_byte;
         REG_PAGE_LO:  m_page[7:0]   = r.write_byte;
         REG_COUNT_HI: m_count[15:8] = r.write_byte;
         REG_COUNT_LO: m_count[7:0]  = r.write_byte;
         default: ;
      endcase
      return 8'h00;
   endfunction

   // request driver: next request once the current one is taken and its gap has passed
   always @(negedge clock) begin
      pending_access_type nxt;
      if (!req_valid || req_took) begin
         if (pending_accesses.size() != 0 && idle_cycles >= pending_accesses[0].gap) begin
            nxt = pending_accesses.pop_front();
            req_valid      <= 1'b1;
            req_operation  <= nxt.req.operation;
            req_reg_index  <= nxt.req.reg_index;
            req_write_byte <= nxt.req.write_byte;
            idle_cycles    <= 0;
         end else begin
            req_valid <= 1'b0;
            if (idle_cycles < 64) idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response stall: random wait per response, one long hold while requests queue up
   always @(negedge clock) begin
      int n;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= HOLD_AFTER && pending_accesses.size() > 20) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_took) begin
         if (rsp_count % 40 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
         n = rsp_quiet ? 0 : $urandom_range(0, 5);
         rsp_stall  <= (n != 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: mirror reset, csr tracking, response check, request prediction
   always @(posedge clock) begin
      logic [7:0]  want;
      bus_req_type r;
      if (reset) begin
         cfg_large = 1'b0; cfg_present = 1'b0; cfg_protect = 1'b0;
         m_latch = '0; m_last_cmd = '0; m_page = '0; m_count = '0;
         m_offset = '0; m_status = '0; m_errors = '0;
         for (int i = 0; i < STORE_BYTES; i++) store_image[i] = 8'h00;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MEDIA_LARGE:   cfg_large   = csr_data[0];
               CSR_MEDIA_PRESENT: cfg_present = csr_data[0];
               CSR_PROTECT_ON:    cfg_protect = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               log_failure($sformatf("unexpected response read_byte=%02h at %0t",
                                     rsp_read_byte, $realtime));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_read_byte !== want)
                  log_failure($sformatf("response %0d read_byte: expected %02h got %02h",
                                        rsp_count, want, rsp_read_byte));
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            r.operation  = req_operation;
            r.reg_index  = req_reg_index;
            r.write_byte = req_write_byte;
            expected_bytes.push_back(predict_access(r));
         end
      end
      req_took <= !reset && req_valid && !req_stall;
      rsp_took <= !reset && rsp_valid && !rsp_stall;
   end

   task automatic write_csr(input logic [1:0] idx, input logic val);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_media(input logic large_media, input logic present, input logic protect);
      write_csr(CSR_MEDIA_LARGE, large_media);
      write_csr(CSR_MEDIA_PRESENT, present);
      write_csr(CSR_PROTECT_ON, protect);
   endtask

   // sender pause until every response is back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_accesses.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic queue_access(input logic op, input logic [2:0] idx, input logic [7:0] b);
      pending_access_type p;
      if (calm_left == 0) begin
         send_calm = ($urandom_range(0, 3) == 0);
         calm_left = 30;
      end
      calm_left--;
      p.req.operation  = op;
      p.req.reg_index  = idx;
      p.req.write_byte = b;
      p.gap = send_calm ? 0 : $urandom_range(0, 5);
      pending_accesses.push_back(p);
      queued_total++;
   endtask

   // page setup, command and a run of data accesses with the odd status poll
   task automatic queue_transfer(input logic to_media);
      logic [15:0] pg;
      logic [15:0] pool [4];
      int          n;
      pool = '{16'h0000, 16'h0001, 16'h03ff, 16'hfc07};
      pg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pool[$urandom_range(0, 3)];
      queue_access(OP_WRITE, REG_PAGE_HI, pg[15:8]);
      queue_access(OP_WRITE, REG_PAGE_LO, pg[7:0]);
      if ($urandom_range(0, 4) != 0) begin
         queue_access(OP_WRITE, REG_COUNT_HI,
                      ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
         queue_access(OP_WRITE, REG_COUNT_LO, 8'($urandom_range(0, 3)));
      end
      queue_access(OP_WRITE, REG_CMD, to_media ? CMD_WRITE : CMD_READ);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 40);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 15) == 0)
            queue_access(OP_READ, REG_STATUS, 8'($urandom));
         else
            queue_access(to_media ? OP_WRITE : OP_READ, REG_DATA, 8'($urandom));
      end
   endtask

   // random bus accesses, commands biased towards the known codes
   task automatic queue_noise(input int n);
      logic       op;
      logic [2:0] idx;
      logic [7:0] b;
      logic [7:0] codes [4];
      codes = '{CMD_READ, CMD_WRITE, CMD_RESET, CMD_RESET_ALT};
      for (int k = 0; k < n; k++) begin
         op  = 1'($urandom);
         idx = 3'($urandom);
         b   = 8'($urandom);
         if (op == OP_WRITE && idx == REG_CMD && $urandom_range(0, 1) == 0)
            b = codes[$urandom_range(0, 3)];
         queue_access(op, idx, b);
      end
   endtask

   initial begin
      logic large_cfg   [8];
      logic present_cfg [8];
      logic protect_cfg [8];
      int   phase;
      int   phase_start;
      int   pick;
      large_cfg   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      present_cfg = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      protect_cfg = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // no media: error paths, undefined commands, fixed registers
      set_media(1'b0, 1'b0, 1'b0);
      queue_access(OP_READ,  REG_STATUS,   8'h00);
      queue_access(OP_READ,  REG_ERROR,    8'hff);
      queue_access(OP_WRITE, REG_CMD,      CMD_READ);
      queue_access(OP_READ,  REG_STATUS,   8'h00);
      queue_access(OP_READ,  REG_ERROR,    8'h00);
      queue_access(OP_WRITE, REG_CMD,      8'h00);
      queue_access(OP_READ,  REG_ERROR,    8'h00);
      queue_access(OP_WRITE, REG_CMD,      8'hff);
      queue_access(OP_WRITE, REG_DATA,     8'hff);
      queue_access(OP_READ,  REG_DATA,     8'h00);
      queue_access(OP_WRITE, REG_STATUS,   8'h55);
      queue_access(OP_WRITE, REG_ERROR,    8'haa);
      queue_access(OP_READ,  REG_CMD,      8'h00);
      queue_access(OP_READ,  REG_PAGE_HI,  8'h00);
      queue_access(OP_READ,  REG_PAGE_LO,  8'h00);
      queue_access(OP_READ,  REG_COUNT_HI, 8'h00);
      queue_access(OP_READ,  REG_COUNT_LO, 8'h00);
      queue_access(OP_WRITE, REG_CMD,      CMD_WRITE);
      queue_access(OP_READ,  REG_STATUS,   8'h00);
      wait_idle();

      // media in, write protected: protected write, resets, page number high bits
      set_media(1'b0, 1'b1, 1'b1);
      queue_access(OP_WRITE, REG_CMD,      CMD_WRITE);
      queue_access(OP_READ,  REG_STATUS,   8'h00);
      queue_access(OP_WRITE, REG_PAGE_HI,  8'hff);
      queue_access(OP_WRITE, REG_PAGE_LO,  8'hff);
      queue_access(OP_WRITE, REG_CMD,      CMD_RESET);
      queue_access(OP_WRITE, REG_CMD,      CMD_RESET_ALT);
      queue_access(OP_READ,  REG_DATA,     8'h00);
      wait_idle();

      // random phases over the media settings
      phase = 0;
      while (phase < 8 || queued_total < 400) begin
         set_media(large_cfg[phase % 8], present_cfg[phase % 8], protect_cfg[phase % 8]);
         phase_start = queued_total;
         while (queued_total - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) queue_transfer(1'b1);
            else if (pick <= 6) queue_transfer(1'b0);
            else if (pick <= 8) queue_noise($urandom_range(1, 8));
            else begin
               queue_access(OP_READ, REG_STATUS, 8'($urandom));
               queue_access(OP_READ, REG_ERROR, 8'($urandom));
            end
         end
         wait_idle();
         phase++;
      end

      repeat (4) @(posedge clock);
      if (expected_bytes.size() != 0)
         log_failure($sformatf("%0d responses never arrived", expected_bytes.size()));
      if (fail_count == 0)
         $display("bubble_memory_page_controller regression: pass");
      else
         $display("bubble_memory_page_controller regression: fail");
      $finish;
   end

   // watchdog, allows for the store clearing pass after reset
   initial begin
      #10_000_000;
      $display("bubble_memory_page_controller regression: fail");
      $finish;
   end

endmodule

@@ bubble_memory_page_controller.f @@
hdl/bmpc_pkg.sv
hdl/bmpc_store.sv
hdl/bmpc_ctrl.sv
hdl/bmpc_resp_buf.sv
hdl/bubble_memory_page_controller.sv
test/bubble_memory_page_controller_tb.sv
